@@ rtl/aabb_pkg.sv @@
// Shared types and constants of the AABB broad-phase overlap tracker.
package aabb_pkg;

  localparam int unsigned ID_BITS        = 6;
  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned TOTAL_BITS     = 11;
  localparam int unsigned OUT_DATA_W     = 16;
  localparam int unsigned DEF_MAX_BOXES  = 64;
  localparam int unsigned DEF_COORD_BITS = 16;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ROW,
    S_QUERY,
    S_DONE
  } state_e;

endpackage

@@ rtl/aabb_broadphase_overlap_tracker.sv @@
// Top level of the AABB broad-phase overlap tracker: sequencer, counter and memories.
//
//  channel  | dir | transfer moves
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | one command: tuser = command, tdata = ids and bounds
//  m_axis   | out | one result per command: overlap bit, pair count, status
//
// Sequence: a carried-out insert/update scans every box slot, reading one stored
//   box and one matrix row per cycle (one read port per memory), then writes the
//   new row through the drain and row states. A query reads one row; rejected or
//   unknown commands go straight to the done state.
// Reset: matrix rows start cleared through per-row valid bits, present flags
//   and pair count reset to zero; no clearing pass is needed.
// Stalls: a result waits in the output register; the sequencer holds in its
//   done state only if a second result is ready before the first is taken.
module aabb_broadphase_overlap_tracker #(
  parameter  int unsigned MAX_BOXES  = aabb_pkg::DEF_MAX_BOXES,
  parameter  int unsigned COORD_BITS = aabb_pkg::DEF_COORD_BITS,
  localparam int unsigned IN_DATA_W  =
    ((2 * aabb_pkg::ID_BITS + 4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: box_id, other_id, left_x, low_y, right_x, high_y, zero pad
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,
  // tuser: command
  input  logic [aabb_pkg::CMD_BITS-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit up: overlapping, pair_total, status, zero pad
  output logic [aabb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import aabb_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BOXES);
  localparam int unsigned BOX_W   = 4 * COORD_BITS;
  localparam int unsigned OUT_PAD = OUT_DATA_W - 1 - TOTAL_BITS - 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);

  // ---------------------------------------------------------------- input decode
  logic [ID_BITS-1:0] in_box_id, in_other_id;
  logic [BOX_W-1:0]   in_box;
  cmd_e               in_cmd;
  logic [IDX_W-1:0]   a_idx, b_idx;
  logic               a_ok, b_ok, a_in_range, b_in_range;

  assign in_box_id   = s_axis_tdata[ID_BITS-1:0];
  assign in_other_id = s_axis_tdata[2*ID_BITS-1:ID_BITS];
  assign in_box      = s_axis_tdata[2*ID_BITS +: BOX_W];
  assign in_cmd      = cmd_e'(s_axis_tuser);

  // ids beyond the box count behave as absent boxes
  assign a_in_range = 32'(in_box_id) < 32'(MAX_BOXES);
  assign b_in_range = 32'(in_other_id) < 32'(MAX_BOXES);
  assign a_idx      = IDX_W'(in_box_id);
  assign b_idx      = IDX_W'(in_other_id);

  // ---------------------------------------------------------------- state
  state_e                state_q, state_d;
  logic [IDX_W-1:0]      j_q;          // scan read index
  logic [IDX_W-1:0]      id_q;         // box under insert/update, or first query box
  logic [IDX_W-1:0]      other_q;      // second query box
  logic [BOX_W-1:0]      box_q;        // bounds of the box under test
  logic                  proc_valid_q; // read data of a present, other box arrives
  logic [IDX_W-1:0]      proc_idx_q;
  logic [MAX_BOXES-1:0]  row_acc_q;    // new matrix row of the box under test
  logic [MAX_BOXES-1:0]  present_q;
  logic [TOTAL_BITS-1:0] pair_cnt_q;
  logic                  hit_q;
  status_e               status_q, status_acc;
  logic                  m_valid_q;
  logic                  out_hit_q;
  logic [TOTAL_BITS-1:0] out_total_q;
  status_e               out_status_q;

  // ---------------------------------------------------------------- memories
  logic                  bnd_we, row_re, row_we, issue, load_out, accept;
  logic [IDX_W-1:0]      row_raddr, row_waddr;
  logic [MAX_BOXES-1:0]  row_wdata, row_rd, proc_row;
  logic [BOX_W-1:0]      bnd_rd;
  logic                  meet, old_bit;

  aabb_bounds_mem #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_bounds (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (a_idx),
    .wdata_i (in_box),
    .re_i    (issue),
    .raddr_i (j_q),
    .rdata_o (bnd_rd)
  );

  aabb_row_mem #(
    .MAX_BOXES (MAX_BOXES)
  ) u_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  aabb_pair_test #(
    .COORD_BITS (COORD_BITS)
  ) u_test (
    .a_i    (box_q),
    .b_i    (bnd_rd),
    .meet_o (meet)
  );

  // Row j holds bit id of the symmetric matrix, so the old pair bit and the
  // mirrored write both come from the row just read.
  assign old_bit = row_rd[id_q];
  always_comb begin
    proc_row        = row_rd;
    proc_row[id_q]  = meet;
  end

  // ---------------------------------------------------------------- sequencer
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    bnd_we        = 1'b0;
    row_re        = 1'b0;
    row_raddr     = j_q;
    row_we        = 1'b0;
    row_waddr     = proc_idx_q;
    row_wdata     = proc_row;
    issue         = 1'b0;
    load_out      = 1'b0;
    status_acc    = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        unique case (in_cmd)
          CMD_INSERT, CMD_UPDATE: begin
            if (!a_in_range) begin
              status_acc = ST_ABSENT;
            end else if (in_cmd == CMD_INSERT && a_ok) begin
              status_acc = ST_PRESENT;
            end else if (in_cmd == CMD_UPDATE && !a_ok) begin
              status_acc = ST_ABSENT;
            end
          end
          CMD_QUERY: begin
            if (!a_ok || !b_ok) begin
              status_acc = ST_ABSENT;
            end
          end
          default: status_acc = ST_OK;
        endcase
        if (s_axis_tvalid) begin
          state_d = S_DONE;
          if ((in_cmd == CMD_INSERT || in_cmd == CMD_UPDATE) && status_acc == ST_OK) begin
            bnd_we  = 1'b1;
            state_d = S_SCAN;
          end else if (in_cmd == CMD_QUERY && status_acc == ST_OK) begin
            row_re    = 1'b1;
            row_raddr = a_idx;
            state_d   = S_QUERY;
          end
        end
      end
      S_SCAN: begin
        issue  = 1'b1;
        row_re = 1'b1;
        if (j_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_ROW;
      S_ROW: begin
        row_we    = 1'b1;
        row_waddr = id_q;
        row_wdata = row_acc_q;
        state_d   = S_DONE;
      end
      S_QUERY: state_d = S_DONE;
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // read-modify-write of the mirrored bit in row j
    if (proc_valid_q) begin
      row_we = 1'b1;
    end
  end

  always_comb begin
    a_ok = a_in_range && present_q[a_idx];
    b_ok = b_in_range && present_q[b_idx];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      j_q          <= '0;
      proc_valid_q <= 1'b0;
      present_q    <= '0;
      pair_cnt_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      proc_valid_q <= issue && present_q[j_q] && (j_q != id_q);
      if (accept) begin
        j_q <= '0;
      end else if (issue) begin
        j_q <= j_q + 1'b1;
      end
      if (bnd_we) begin
        present_q[a_idx] <= 1'b1;
      end
      if (proc_valid_q) begin
        if (meet && !old_bit) begin
          pair_cnt_q <= pair_cnt_q + 1'b1;
        end else if (!meet && old_bit) begin
          pair_cnt_q <= pair_cnt_q - 1'b1;
        end
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    proc_idx_q <= j_q;
    if (accept) begin
      id_q      <= a_idx;
      other_q   <= b_idx;
      box_q     <= in_box;
      row_acc_q <= '0;
      hit_q     <= 1'b0;
      status_q  <= status_acc;
    end
    if (proc_valid_q) begin
      row_acc_q[proc_idx_q] <= meet;
    end
    if (state_q == S_QUERY) begin
      hit_q <= row_rd[other_q];
    end
    if (load_out) begin
      out_hit_q    <= hit_q;
      out_total_q  <= pair_cnt_q;
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_status_q, out_total_q, out_hit_q};

  // ---------------------------------------------------------------- assertions
  // the scan never rewrites the row of the box under test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_valid_q |-> proc_idx_q != id_q)
    else $error("scan write hit the row under test");

  // the final row write never collides with a scan write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |-> !proc_valid_q)
    else $error("row write collides with scan write");

  // boxes are never removed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (present_q & $past(present_q)) == $past(present_q))
    else $error("present flag lost");

  // a result is only loaded from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");

endmodule

@@ rtl/aabb_bounds_mem.sv @@
// Box bounds memory: one write port, one registered read port.
module aabb_bounds_mem #(
  parameter int unsigned MAX_BOXES  = aabb_pkg::DEF_MAX_BOXES,
  parameter int unsigned COORD_BITS = aabb_pkg::DEF_COORD_BITS
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(MAX_BOXES)-1:0]    waddr_i,
  input  logic [4*COORD_BITS-1:0]         wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(MAX_BOXES)-1:0]    raddr_i,
  output logic [4*COORD_BITS-1:0]         rdata_o
);

  logic [4*COORD_BITS-1:0] mem_q [MAX_BOXES];
  logic [4*COORD_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

@@ rtl/aabb_row_mem.sv @@
// Overlap matrix row memory; per-row valid bits make unwritten rows read as zero.
module aabb_row_mem #(
  parameter int unsigned MAX_BOXES = aabb_pkg::DEF_MAX_BOXES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [$clog2(MAX_BOXES)-1:0]    waddr_i,
  input  logic [MAX_BOXES-1:0]            wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(MAX_BOXES)-1:0]    raddr_i,
  output logic [MAX_BOXES-1:0]            rdata_o
);

  logic [MAX_BOXES-1:0] mem_q [MAX_BOXES];
  logic [MAX_BOXES-1:0] rd_q;
  logic [MAX_BOXES-1:0] valid_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

@@ rtl/aabb_pair_test.sv @@
// Inclusive two-axis box overlap test.
module aabb_pair_test #(
  parameter int unsigned COORD_BITS = aabb_pkg::DEF_COORD_BITS
) (
  input  logic [4*COORD_BITS-1:0] a_i,
  input  logic [4*COORD_BITS-1:0] b_i,
  output logic                    meet_o
);

  logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1;
  logic signed [COORD_BITS-1:0] bx0, by0, bx1, by1;

  // packing from the low bits up: min x, min y, max x, max y
  assign ax0 = $signed(a_i[0*COORD_BITS +: COORD_BITS]);
  assign ay0 = $signed(a_i[1*COORD_BITS +: COORD_BITS]);
  assign ax1 = $signed(a_i[2*COORD_BITS +: COORD_BITS]);
  assign ay1 = $signed(a_i[3*COORD_BITS +: COORD_BITS]);
  assign bx0 = $signed(b_i[0*COORD_BITS +: COORD_BITS]);
  assign by0 = $signed(b_i[1*COORD_BITS +: COORD_BITS]);
  assign bx1 = $signed(b_i[2*COORD_BITS +: COORD_BITS]);
  assign by1 = $signed(b_i[3*COORD_BITS +: COORD_BITS]);

  assign meet_o = !((ax1 < bx0) || (ax0 > bx1) || (ay1 < by0) || (ay0 > by1));

endmodule

@@ test/tb.sv @@
// Testbench for the AABB broad-phase overlap tracker: directed and random commands checked by a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam int unsigned BOXES       = DEF_MAX_BOXES;
  localparam int unsigned COORD_W     = DEF_COORD_BITS;
  localparam int unsigned IN_W        = ((2 * ID_BITS + 4 * COORD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W       = IN_W - 2 * ID_BITS - 4 * COORD_W;
  localparam int unsigned PER_PHASE   = 400;   // counted commands per idling phase
  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any transfer

  // Command code the block answers with status ok but does not act on; it has no member in cmd_e.
  localparam logic [CMD_BITS-1:0] CMD_IGNORED = 2'd3;

  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ID_BITS-1:0] box_id_t;

  // Last member sits in the low bits, so this matches the tdata layout.
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    coord_t           hy, rx, ly, lx;
    box_id_t          other, id;
  } box_cmd_t;

  typedef struct packed {
    logic [OUT_DATA_W-TOTAL_BITS-4:0] pad;
    status_e                          status;
    logic [TOTAL_BITS-1:0]            total;
    logic                             hit;
  } outcome_t;

  // Mirror of the tracker state plus the queue of outcomes still owed by the block.
  class overlap_scoreboard;
    bit signed [COORD_W-1:0] min_x[BOXES], min_y[BOXES], max_x[BOXES], max_y[BOXES];
    bit [BOXES-1:0]          present;
    bit [BOXES-1:0]          meets[BOXES];
    bit [TOTAL_BITS-1:0]     pairs;
    outcome_t                pending[$];
    int                      mismatches, results, hits, peak;
    int                      by_status[4];

    // Inclusive on both axes: shared edges and corners count.
    function bit boxes_touch(int a, int b);
      return !(max_x[a] < min_x[b] || min_x[a] > max_x[b] ||
               max_y[a] < min_y[b] || min_y[a] > max_y[b]);
    endfunction

    function void note_command(logic [CMD_BITS-1:0] cmd, box_cmd_t f);
      outcome_t e;
      bit       now;
      e        = '0;
      e.status = ST_OK;
      case (cmd)
        CMD_INSERT, CMD_UPDATE: begin
          if (cmd == CMD_INSERT && present[f.id]) begin
            e.status = ST_PRESENT;
          end else if (cmd == CMD_UPDATE && !present[f.id]) begin
            e.status = ST_ABSENT;
          end else begin
            min_x[f.id]   = f.lx;
            min_y[f.id]   = f.ly;
            max_x[f.id]   = f.rx;
            max_y[f.id]   = f.hy;
            present[f.id] = 1'b1;
            // re-test the written box against every other present box
            for (int j = 0; j < BOXES; j++) begin
              if (j != f.id && present[j]) begin
                now = boxes_touch(f.id, j);
                if (now && !meets[f.id][j]) pairs++;
                else if (!now && meets[f.id][j]) pairs--;
                meets[f.id][j] = now;
                meets[j][f.id] = now;
              end
            end
          end
        end
        CMD_QUERY: begin
          if (!present[f.id] || !present[f.other]) e.status = ST_ABSENT;
          else e.hit = meets[f.id][f.other];
        end
        default: ;
      endcase
      e.total = pairs;
      pending.push_back(e);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result 0x%h with no command outstanding", got));
        return;
      end
      want = pending.pop_front();
      results++;
      by_status[int'(want.status)]++;
      if (want.hit) hits++;
      if (want.total > peak) peak = want.total;
      if (got.hit !== want.hit)
        report_mismatch($sformatf("result %0d overlapping: expected %0d, got %0d",
                                  results, want.hit, got.hit));
      if (got.total !== want.total)
        report_mismatch($sformatf("result %0d pair_total: expected %0d, got %0d",
                                  results, want.total, got.total));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                  results, want.status, got.status));
    endtask
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_W-1:0]           s_axis_tdata  = '0;
  logic [CMD_BITS-1:0]       s_axis_tuser  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]     m_axis_tdata;

  int unsigned               tx_idle_pct   = 9;
  int unsigned               rx_idle_pct   = 77;
  overlap_scoreboard         sb            = new();

  aabb_broadphase_overlap_tracker #(
    .MAX_BOXES  (BOXES),
    .COORD_BITS (COORD_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Results are checked before the same-edge command is noted; a command can
  // never produce its result in the cycle it is taken.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(outcome_t'(m_axis_tdata));
    if (s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tuser, box_cmd_t'(s_axis_tdata));
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Called right after an accepting edge (or after a pause); returns on acceptance.
  task automatic send_command(input logic [CMD_BITS-1:0] cmd, input box_cmd_t f);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = f;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic box_cmd_t make_box(int id, int other, int lx, int ly, int rx, int hy);
    box_cmd_t f;
    f       = '0;
    f.id    = box_id_t'(id);
    f.other = box_id_t'(other);
    f.lx    = coord_t'(lx);
    f.ly    = coord_t'(ly);
    f.rx    = coord_t'(rx);
    f.hy    = coord_t'(hy);
    return f;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(2))
      0:       return C_MIN;
      1:       return C_MAX;
      default: return '0;
    endcase
  endfunction

  // Mostly boxes in a small world so pairs come and go; some full-range and
  // edge-of-range bounds, which also give inverted boxes.
  function automatic box_cmd_t random_bounds();
    box_cmd_t f;
    int       cx, cy, w, h, pick;
    f    = '0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // coarse grid: exact edge contact is common
      cx = (int'($urandom_range(40)) - 20) * 100;
      cy = (int'($urandom_range(40)) - 20) * 100;
      w  = int'($urandom_range(12)) * 100;
      h  = int'($urandom_range(12)) * 100;
    end else if (pick < 75) begin
      cx = int'($urandom_range(4000)) - 2000;
      cy = int'($urandom_range(4000)) - 2000;
      w  = int'($urandom_range(1500));
      h  = int'($urandom_range(1500));
    end else if (pick < 92) begin
      f.lx = coord_t'($urandom);
      f.ly = coord_t'($urandom);
      f.rx = coord_t'($urandom);
      f.hy = coord_t'($urandom);
      return f;
    end else begin
      f.lx = extreme_coord();
      f.ly = extreme_coord();
      f.rx = extreme_coord();
      f.hy = extreme_coord();
      return f;
    end
    f.lx = coord_t'(cx);
    f.ly = coord_t'(cy);
    f.rx = coord_t'(cx + w);
    f.hy = coord_t'(cy + h);
    return f;
  endfunction

  // Biased toward boxes already in the tracker; falls back to any index.
  function automatic box_id_t pick_present();
    box_id_t id;
    id = '0;
    for (int k = 0; k < 16; k++) begin
      id = box_id_t'($urandom_range(BOXES - 1));
      if (sb.present[id]) return id;
    end
    return id;
  endfunction

  initial begin : stimulus
    logic [CMD_BITS-1:0] cmd;
    box_cmd_t            f;
    int unsigned         issued, roll;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: absent boxes, duplicate insert, full-range and point boxes,
    // corner contact, a one-unit gap, inverted bounds, self query, moves.
    send_command(CMD_QUERY,   make_box(0, 1, 0, 0, 0, 0));
    send_command(CMD_UPDATE,  make_box(5, 0, 0, 0, 10, 10));
    send_command(CMD_INSERT,  make_box(0, 0, C_MIN, C_MIN, C_MAX, C_MAX));
    send_command(CMD_INSERT,  make_box(0, 0, 1, 1, 2, 2));
    send_command(CMD_INSERT,  make_box(63, 0, C_MAX, C_MAX, C_MAX, C_MAX));
    send_command(CMD_INSERT,  make_box(1, 0, 0, 0, 10, 10));
    send_command(CMD_INSERT,  make_box(2, 0, 11, 0, 20, 10));
    send_command(CMD_INSERT,  make_box(3, 0, 10, 10, 15, 15));
    send_command(CMD_INSERT,  make_box(4, 0, 100, 100, 50, 50));
    send_command(CMD_QUERY,   make_box(1, 3, 0, 0, 0, 0));
    send_command(CMD_QUERY,   make_box(1, 2, 0, 0, 0, 0));
    send_command(CMD_QUERY,   make_box(3, 3, 0, 0, 0, 0));
    send_command(CMD_QUERY,   make_box(1, 9, 0, 0, 0, 0));
    send_command(CMD_QUERY,   make_box(63, 0, 0, 0, 0, 0));
    send_command(CMD_UPDATE,  make_box(3, 0, 1000, 1000, 1001, 1001));
    send_command(CMD_QUERY,   make_box(3, 1, 0, 0, 0, 0));
    send_command(CMD_UPDATE,  make_box(3, 0, 10, 10, 15, 15));
    send_command(CMD_IGNORED, make_box(63, 42, C_MAX, C_MIN, C_MIN, C_MAX));
    send_command(CMD_UPDATE,  make_box(63, 0, C_MIN, C_MIN, C_MIN, C_MIN));
    send_command(CMD_QUERY,   make_box(0, 63, 0, 0, 0, 0));
    send_command(CMD_QUERY,   make_box(4, 0, 0, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 9;  rx_idle_pct = 77; end
        1: begin tx_idle_pct = 77; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // let the block run dry once before the sender picks up again
      if (phase == 1) hold_until_drained();
      issued = 0;
      while (issued < PER_PHASE) begin
        roll    = $urandom_range(99);
        f       = random_bounds();
        f.id    = box_id_t'($urandom_range(BOXES - 1));
        f.other = box_id_t'($urandom_range(BOXES - 1));
        if (roll < 15) begin
          cmd = CMD_INSERT;
        end else if (roll < 55) begin
          cmd  = CMD_UPDATE;
          f.id = pick_present();
        end else if (roll < 85) begin
          cmd     = CMD_QUERY;
          f.id    = pick_present();
          f.other = pick_present();
        end else if (roll < 90) begin
          cmd = CMD_UPDATE;
        end else if (roll < 96) begin
          cmd = CMD_QUERY;
        end else begin
          cmd = CMD_IGNORED;
        end
        send_command(cmd, f);
        if (cmd != CMD_IGNORED) issued++;
      end
    end

    hold_until_drained();
    repeat (BOXES + 8) @(posedge clk_i);

    $display("covered %0d results, %0d overlapping queries; status ok/present/absent %0d/%0d/%0d",
             sb.results, sb.hits, sb.by_status[ST_OK], sb.by_status[ST_PRESENT],
             sb.by_status[ST_ABSENT]);
    $display("peak pair count %0d with %0d boxes present at the end, %0d mismatches",
             sb.peak, $countones(sb.present), sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aabb_pkg.sv
rtl/aabb_bounds_mem.sv
rtl/aabb_row_mem.sv
rtl/aabb_pair_test.sv
rtl/aabb_broadphase_overlap_tracker.sv
test/tb.sv
